[hdl/assert_macros.svh]
// assertion macros shared by the rtl
// depends on clk_i and rst_ni being visible at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

[hdl/stbs_pkg.sv]
// types and constants for the sorted table binary search
// no dependencies
package stbs_pkg;

  localparam int DataW = 32;
  localparam int SlotW = 10;
  localparam int PosW  = 10;
  localparam int CntW  = 11;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SEARCH = 1'b1
  } act_e;

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } state_e;

  typedef struct packed {
    logic            strobe;
    logic            found;
    logic [PosW-1:0] position;
  } res_t;

endpackage

[hdl/stbs_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module stbs_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/stbs_ctrl.sv]
// search sequencer: bounds, midpoint, compare and result register
// depends on stbs_pkg and drives the table ram ports
module stbs_ctrl #(
  parameter int TableDepth = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  stbs_pkg::act_e                 action_i,
  input  logic [stbs_pkg::SlotW-1:0]     slot_i,
  input  logic [stbs_pkg::DataW-1:0]     entry_value_i,
  input  logic [stbs_pkg::DataW-1:0]     search_key_i,
  input  logic [stbs_pkg::CntW-1:0]      used_entries_i,
  output logic                           ram_we_o,
  output logic [$clog2(TableDepth)-1:0]  ram_waddr_o,
  output logic [stbs_pkg::DataW-1:0]     ram_wdata_o,
  output logic [$clog2(TableDepth)-1:0]  ram_raddr_o,
  input  logic [stbs_pkg::DataW-1:0]     ram_rdata_i,
  output stbs_pkg::res_t                 res_o
);

  localparam int AW   = $clog2(TableDepth);
  localparam int CW   = $clog2(TableDepth + 1);
  localparam int MW   = (CW > stbs_pkg::CntW) ? CW : stbs_pkg::CntW;
  localparam int SW   = (CW > stbs_pkg::SlotW) ? CW : stbs_pkg::SlotW;
  localparam int PosW = stbs_pkg::PosW;

  stbs_pkg::state_e state_q, state_d;
  stbs_pkg::res_t   res_q, res_d;

  logic [CW-1:0]               low_q, low_d, high_q, high_d;
  logic [AW-1:0]               mid_q, mid_d;
  logic [stbs_pkg::DataW-1:0]  key_q, key_d;
  logic [CW-1:0]               count;
  logic [MW-1:0]               used_ext;
  logic [CW:0]                 sum;
  logic                        accept, is_search, range_ok, hit, above;

  assign accept    = start && !busy;
  assign is_search = (action_i == stbs_pkg::ACT_SEARCH);
  assign busy      = (state_q != stbs_pkg::ST_IDLE);

  assign used_ext = MW'(used_entries_i);
  assign count    = (used_ext > MW'(TableDepth)) ? CW'(TableDepth) : CW'(used_ext);

  // writes go straight to the table on transfer
  assign ram_we_o    = accept && !is_search && (SW'(slot_i) < SW'(TableDepth));
  assign ram_waddr_o = AW'(slot_i);
  assign ram_wdata_o = entry_value_i;

  assign hit   = (state_q == stbs_pkg::ST_PROBE) && (ram_rdata_i == key_q);
  assign above = $signed(ram_rdata_i) > $signed(key_q);

  // interval is [low, high) with high exclusive
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    key_d  = key_q;
    if (state_q == stbs_pkg::ST_IDLE) begin
      low_d  = '0;
      high_d = count;
      key_d  = search_key_i;
    end else if (above) begin
      high_d = CW'(mid_q);
    end else begin
      low_d = CW'(mid_q) + CW'(1);
    end
  end

  assign range_ok    = low_d < high_d;
  assign sum         = {1'b0, low_d} + {1'b0, high_d} - (CW + 1)'(1);
  assign mid_d       = sum[AW:1];
  assign ram_raddr_o = mid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      stbs_pkg::ST_IDLE: begin
        if (accept && is_search && range_ok) begin
          state_d = stbs_pkg::ST_PROBE;
        end
      end
      stbs_pkg::ST_PROBE: begin
        if (hit || !range_ok) begin
          state_d = stbs_pkg::ST_IDLE;
        end
      end
      default: state_d = stbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res_d = '0;
    case (state_q)
      stbs_pkg::ST_IDLE: begin
        res_d.strobe = accept && is_search && !range_ok;
      end
      stbs_pkg::ST_PROBE: begin
        res_d.strobe   = hit || !range_ok;
        res_d.found    = hit;
        res_d.position = hit ? PosW'(mid_q) : '0;
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stbs_pkg::ST_IDLE;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == stbs_pkg::ST_IDLE && accept && is_search)
        || state_q == stbs_pkg::ST_PROBE) begin
      low_q  <= low_d;
      high_q <= high_d;
      mid_q  <= mid_d;
      key_q  <= key_d;
    end
  end

  assign res_o = res_q;

endmodule

[hdl/sorted_table_binary_search.sv]
// Binary search over a table of signed 32-bit entries held in one synchronous ram.
// A write goes straight to the table when accepted. A search makes P probes, one ram read
// per cycle, with P up to clog2(count)+1 (11 at 1024 entries).
// The result strobe comes in the cycle after the last probe; the receiver cannot stall.
// Reset clears the count register and control; table contents are undefined until written.
`include "assert_macros.svh"
module sorted_table_binary_search #(
  parameter int TableDepth = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action_i,
  input  logic [stbs_pkg::SlotW-1:0]  slot_i,
  input  logic [stbs_pkg::DataW-1:0]  entry_value_i,
  input  logic [stbs_pkg::DataW-1:0]  search_key_i,
  output logic                        done_o,
  output logic                        found_o,
  output logic [stbs_pkg::PosW-1:0]   position_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [stbs_pkg::CntW-1:0]   used_entries_i
);

  localparam int AW = $clog2(TableDepth);

  logic [stbs_pkg::CntW-1:0]  used_q;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [stbs_pkg::DataW-1:0] ram_wdata, ram_rdata;
  stbs_pkg::res_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      used_q <= used_entries_i;
    end
  end

  stbs_ctrl #(
    .TableDepth(TableDepth)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (stbs_pkg::act_e'(action_i)),
    .slot_i        (slot_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .used_entries_i(used_q),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .res_o         (res)
  );

  stbs_ram #(
    .Width(stbs_pkg::DataW),
    .Depth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign done_o     = res.strobe;
  assign found_o    = res.found;
  assign position_o = res.position;

  `ASSERT_SAME(a_miss_pos_zero, done_o && !found_o, position_o == '0)
  `ASSERT_SAME(a_done_not_busy, done_o, !busy)
  `ASSERT_NEXT(a_empty_miss, start && !busy && action_i == stbs_pkg::ACT_SEARCH && used_q == '0,
               done_o && !found_o)
  `ASSERT_NEXT(a_write_quiet, start && !busy && action_i == stbs_pkg::ACT_WRITE, !done_o)

endmodule
